FILE: design/swtl_pkg.sv
`default_nettype none

package swtl_pkg;

  localparam int VERTICES_DEF = 4096;
  localparam int BONES_DEF    = 256;
  localparam int ROW_SLOTS    = 4;

  localparam logic [15:0] ONE_Q15 = 16'd32768;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [11:0] vertex_index;
    logic [7:0]  bone_index;
    logic [15:0] weight;
  } swtl_in_t;

  typedef struct packed {
    logic [11:0] row_vertex;
    logic [7:0]  bone_a;
    logic [7:0]  bone_b;
    logic [7:0]  bone_c;
    logic [7:0]  bone_d;
    logic [15:0] norm_a;
    logic [15:0] norm_b;
    logic [15:0] norm_c;
    logic [15:0] norm_d;
    logic        unassigned;
  } swtl_out_t;

  // One memory row holds a whole vertex: fill count plus four slots.
  // Used slots always form a prefix, so the count replaces per-slot flags.
  typedef struct packed {
    logic [2:0]                     cnt;
    logic [ROW_SLOTS-1:0][7:0]      bone;
    logic [ROW_SLOTS-1:0][15:0]     wt;
  } swtl_row_t;

endpackage

`default_nettype wire

FILE: design/swtl_ram.sv
`default_nettype none

module swtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/skin_weight_top4_limiter.sv
`default_nettype none

// Bone influence store: up to four (bone, weight) slots per vertex.
// Input channel in_valid/in_stall/in_item carries assign and read items;
// an item is taken at a clock edge with in_valid high and in_stall low.
// An assign fills the first free slot of its vertex, or on a full row
// replaces the first smallest weight when the new weight is larger.
// It produces no result and occupies the block for a row read, then a
// write back. A read produces one item on out_valid/out_stall/out_item
// with the four bones and weights normalized to sum 1.0 (Q1.15).
// A read passes through row read and setup, 16 steps of four parallel
// radix-2 dividers and output load before out_valid rises; no new item
// is taken until the read has finished. An item is taken again once the
// block is idle, even while an earlier result still sits in the output
// register. After reset, a clearing pass writes every row with in_stall
// high. When the receiver stalls, the finished result waits in the
// sequencer until the output register frees up.
module skin_weight_top4_limiter
  import swtl_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF,
  parameter int BONES    = BONES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire swtl_in_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output swtl_out_t      out_item
);

  localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int RW = $bits(swtl_row_t);
  localparam logic [16:0] VLIM = 17'(VERTICES);
  localparam logic [16:0] BLIM = 17'(BONES);
  localparam logic [AW-1:0] LAST_ROW = AW'(VERTICES - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RMW   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  swtl_in_t                     item_r, item_nxt;
  logic [ROW_SLOTS-1:0][7:0]    bone_r, bone_nxt;
  logic                         unas_r, unas_nxt;
  logic [17:0]                  sum_r, sum_nxt;
  logic [ROW_SLOTS-1:0][18:0]   rem_r, rem_nxt;
  logic [ROW_SLOTS-1:0][15:0]   quo_r, quo_nxt;
  swtl_out_t                    out_r, out_nxt;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  swtl_row_t     rd_row;
  swtl_row_t     new_row;

  logic          accept;
  logic [16:0]   in_vext;
  logic [16:0]   item_vext;
  logic          v_ok;
  logic          b_ok;
  logic          do_wr;
  logic [16:0]   least;
  logic [1:0]    least_at;
  logic          empty;
  logic [ROW_SLOTS-1:0][15:0] rd_wt;
  logic [ROW_SLOTS-1:0][7:0]  rd_bone;
  logic [17:0]   sum_c;
  logic [31:0]   dvd;
  logic [18:0]   trial;
  logic          out_free;

  swtl_ram #(
    .WIDTH (RW),
    .DEPTH (VERTICES)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_row    = swtl_row_t'(ram_rdata);
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_vext   = 17'(in_item.vertex_index);
  assign item_vext = 17'(item_r.vertex_index);
  assign ram_re    = accept;
  assign ram_raddr = in_vext[AW-1:0];
  assign v_ok      = (item_vext < VLIM);
  assign b_ok      = (17'(item_r.bone_index) < BLIM);
  assign out_free  = !out_valid_r || !out_stall;

  // Assign path: fill the next free slot, or replace the first smallest.
  always_comb begin
    least    = 17'h10000;
    least_at = 2'd0;
    for (int s = 0; s < ROW_SLOTS; s++) begin
      if (17'(rd_row.wt[s]) < least) begin
        least    = 17'(rd_row.wt[s]);
        least_at = 2'(s);
      end
    end
    new_row = rd_row;
    do_wr   = 1'b0;
    if (rd_row.cnt < 3'(ROW_SLOTS)) begin
      new_row.bone[rd_row.cnt[1:0]] = item_r.bone_index;
      new_row.wt[rd_row.cnt[1:0]]   = item_r.weight;
      new_row.cnt                   = rd_row.cnt + 3'd1;
      do_wr                         = v_ok && b_ok;
    end else if (least < 17'(item_r.weight)) begin
      new_row.bone[least_at] = item_r.bone_index;
      new_row.wt[least_at]   = item_r.weight;
      do_wr                  = v_ok && b_ok;
    end
  end

  // Read path: mask unused slots, default an empty row to bone 0 at 1.0.
  always_comb begin
    empty = !v_ok || (rd_row.cnt == 3'd0);
    sum_c = '0;
    for (int s = 0; s < ROW_SLOTS; s++) begin
      if (empty) begin
        rd_wt[s]   = (s == 0) ? ONE_Q15 : 16'd0;
        rd_bone[s] = 8'd0;
      end else if (3'(s) < rd_row.cnt) begin
        rd_wt[s]   = rd_row.wt[s];
        rd_bone[s] = rd_row.bone[s];
      end else begin
        rd_wt[s]   = 16'd0;
        rd_bone[s] = 8'd0;
      end
      sum_c = sum_c + 18'(rd_wt[s]);
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) ||
                     ((state_r == ST_RMW) && (item_r.operation == OP_ASSIGN) && do_wr);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : item_vext[AW-1:0];
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : RW'(new_row);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    item_nxt      = item_r;
    bone_nxt      = bone_r;
    unas_nxt      = unas_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_nxt       = out_r;
    dvd           = '0;
    trial         = '0;

    // drop the held result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_item;
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (item_r.operation == OP_ASSIGN) begin
          state_nxt = ST_IDLE;
        end else begin
          bone_nxt = rd_bone;
          unas_nxt = empty;
          sum_nxt  = sum_c;
          step_nxt = 4'd0;
          // dividend w * 2^15 + sum / 2; quotient fits 16 bits
          for (int s = 0; s < ROW_SLOTS; s++) begin
            dvd        = {1'b0, rd_wt[s], 15'd0} + 32'(sum_c >> 1);
            rem_nxt[s] = 19'(dvd[31:16]);
            quo_nxt[s] = dvd[15:0];
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step per lane: shift in a dividend bit, try subtract
        for (int s = 0; s < ROW_SLOTS; s++) begin
          trial = {rem_r[s][17:0], quo_r[s][15]};
          if (trial >= 19'(sum_r)) begin
            rem_nxt[s] = trial - 19'(sum_r);
            quo_nxt[s] = {quo_r[s][14:0], 1'b1};
          end else begin
            rem_nxt[s] = trial;
            quo_nxt[s] = {quo_r[s][14:0], 1'b0};
          end
        end
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_nxt.row_vertex = item_r.vertex_index;
          out_nxt.bone_a     = bone_r[0];
          out_nxt.bone_b     = bone_r[1];
          out_nxt.bone_c     = bone_r[2];
          out_nxt.bone_d     = bone_r[3];
          out_nxt.norm_a     = (sum_r == '0) ? 16'd0 : quo_r[0];
          out_nxt.norm_b     = (sum_r == '0) ? 16'd0 : quo_r[1];
          out_nxt.norm_c     = (sum_r == '0) ? 16'd0 : quo_r[2];
          out_nxt.norm_d     = (sum_r == '0) ? 16'd0 : quo_r[3];
          out_nxt.unassigned = unas_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    bone_r <= bone_nxt;
    unas_r <= unas_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
